FILE: hw/rtl/cscs_pkg.sv
// Shared types, constants and the exp factor table for the causal soft-capped
// softmax row core. No dependencies; all files but the RAM and divider import it.
package cscs_pkg;

  localparam int SCORE_W = 20;
  localparam int ROW_W   = 6;
  localparam int PROB_W  = 17;
  localparam int LEN_W   = 7;
  localparam int CAP_W   = 19;
  localparam int ACC_W   = 31;   // Q30 value up to 1.0
  localparam int FACT_W  = 30;
  localparam int EXPA_W  = 21;   // exp argument, Q11.10
  localparam int EXP_BITS = 14;
  localparam int SUM_W   = 23;
  localparam int EV_W    = 17;

  localparam logic signed [SCORE_W-1:0] MOST_NEG = 20'sh80000;
  localparam logic [ACC_W-1:0]  ONE_Q30  = 31'h4000_0000;
  localparam logic [EXPA_W-1:0] EXP_BIG  = 21'd16384;
  localparam logic [PROB_W-1:0] PROB_ONE = 17'h1_0000;

  localparam logic REG_SEQ_LEN  = 1'b0;
  localparam logic REG_SOFT_CAP = 1'b1;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [ROW_W-1:0]          query_row;
  } item_t;

  typedef struct packed {
    logic [PROB_W-1:0] probability;
    logic [ROW_W-1:0]  column;
    logic              row_end;
  } result_t;

  // one finished row waiting for the softmax passes
  typedef struct packed {
    logic                      bank;
    logic [LEN_W-1:0]          len;
    logic [ROW_W-1:0]          row;
    logic signed [SCORE_W-1:0] max;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef enum logic [2:0] {
    F_IDLE, F_PREP, F_DIV1, F_EXP, F_MUL, F_DIVS, F_DIV2, F_STORE
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_RD, B_EXS, B_EXW, B_P2, B_P2W, B_P2D
  } back_state_t;

  // exp(-2^b/1024) in Q30
  function automatic logic [FACT_W-1:0] exp_factor(input logic [3:0] b);
    logic [FACT_W-1:0] f;
    case (b)
      4'd0:  f = 30'd1072693760;
      4'd1:  f = 30'd1071646719;
      4'd2:  f = 30'd1069555701;
      4'd3:  f = 30'd1065385899;
      4'd4:  f = 30'd1057095000;
      4'd5:  f = 30'd1040706261;
      4'd6:  f = 30'd1008687096;
      4'd7:  f = 30'd947573834;
      4'd8:  f = 30'd836230973;
      4'd9:  f = 30'd651257337;
      4'd10: f = 30'd395007542;
      4'd11: f = 30'd145315154;
      4'd12: f = 30'd19666267;
      4'd13: f = 30'd360200;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

FILE: hw/rtl/causal_softcap_softmax_row_core.sv
// Top level of the causal soft-capped softmax row core: register port,
// row buffer, job queue, front and back sections. Uses cscs_pkg and all cscs_* modules.
//
//   channel  | signals                          | transfer
//   ---------+----------------------------------+-------------------------------
//   input    | start, busy, item                | start high and busy low
//   result   | result_valid, result             | each cycle result_valid is high
//   config   | psel, penable, pwrite, paddr,    | access cycle with pwrite high
//            | pwdata, prdata, pready           |
//
// Without capping a score passes only through the prepare and store states; with
// the cap on it also goes through the 14-bit ratio divider (skipped when the score
// saturates the cap), the 14-step exp unit and the 20-bit divider.
// The back section runs an exp-sum pass over the columns up to the row index, then
// an emit pass that divides for unmasked columns and emits masked ones directly.
// Rows are double buffered; the front stalls at a row start while both buffers
// wait in the back. Synchronous reset; no clearing pass. Results cannot be stalled.
module causal_softcap_softmax_row_core import cscs_pkg::*; #(
  parameter int MAX_SEQ = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  item_t       item,
  output logic        busy,
  output result_t     result,
  output logic        result_valid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW  = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
  localparam int RAW = AW + 1;

  logic [LEN_W-1:0] seq_len;
  logic [CAP_W-1:0] soft_cap;

  logic                      wr_en;
  logic [RAW-1:0]            wr_addr;
  logic signed [SCORE_W-1:0] wr_data;
  logic [RAW-1:0]            rd_addr;
  logic signed [SCORE_W-1:0] rd_data;
  logic                      push;
  logic                      pop;
  logic                      job_valid;
  job_t                      job_w;
  job_t                      job_r;
  rel_t                      rel;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SOFT_CAP) ? 32'(soft_cap) : 32'(seq_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_len  <= LEN_W'(64);
      soft_cap <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_SEQ_LEN:  seq_len  <= pwdata[LEN_W-1:0];
        REG_SOFT_CAP: soft_cap <= pwdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  cscs_front #(.MAX_SEQ(MAX_SEQ)) u_front (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .seq_len(seq_len), .soft_cap(soft_cap),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .push(push), .job(job_w), .rel(rel)
  );

  cscs_ram #(.W(SCORE_W), .DEPTH(2 << AW)) u_row_ram (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .raddr(rd_addr), .rdata(rd_data)
  );

  cscs_jobq u_jobq (
    .clk(clk), .rst(rst), .push(push), .job_in(job_w),
    .pop(pop), .nonempty(job_valid), .job_out(job_r)
  );

  cscs_back #(.MAX_SEQ(MAX_SEQ)) u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job_in(job_r), .pop(pop),
    .rd_addr(rd_addr), .rd_data(rd_data),
    .result(result), .result_valid(result_valid), .rel(rel)
  );

endmodule

FILE: hw/rtl/cscs_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cscs_ram #(
  parameter int W = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/cscs_div.sv
// Restoring divider, one quotient bit per cycle. Caller guarantees that
// num >> QW is below den. No package dependency.
module cscs_div #(
  parameter int NW = 8,
  parameter int DW = 4,
  parameter int QW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [QW-1:0] low;
  logic [CW-1:0] cnt;
  logic          run;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem, low[QW-1]};
  assign diff  = trial - {1'b0, dreg};
  assign ge    = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= DW'(num >> QW);
      low  <= num[QW-1:0];
      dreg <= den;
    end else if (run) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      low <= low << 1;
      quo <= {quo[QW-2:0], ge};
    end
  end

endmodule

FILE: hw/rtl/cscs_exp.sv
// exp(-a) in Q30 for Q11.10 a, one table factor per cycle, one per low argument bit.
// Depends on cscs_pkg for the factor table.
module cscs_exp import cscs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [EXPA_W-1:0] a,
  output logic              done,
  output logic [ACC_W-1:0]  res
);

  localparam int PW = ACC_W + FACT_W;

  logic [EXP_BITS-1:0] abits;
  logic [3:0]          idx;
  logic                run;
  logic [ACC_W-1:0]    acc;
  logic [PW-1:0]       prod;
  logic [PW-1:0]       rnd;

  assign prod = PW'(acc) * PW'(exp_factor(idx));
  assign rnd  = prod + (PW'(1) << 29);
  assign res  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        idx <= '0;
      end else if (run) begin
        idx <= idx + 1'b1;
        if (idx == 4'(EXP_BITS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // 16.0 and above underflows to zero
      acc   <= (a >= EXP_BIG) ? '0 : ONE_Q30;
      abits <= a[EXP_BITS-1:0];
    end else if (run && abits[idx]) begin
      acc <= rnd[PW-1:30];
    end
  end

endmodule

FILE: hw/rtl/cscs_jobq.sv
// Two-entry queue of finished rows between the front and back sections.
// Depends on cscs_pkg for job_t.
module cscs_jobq import cscs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t job_in,
  input  logic pop,
  output logic nonempty,
  output job_t job_out
);

  job_t       slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign nonempty = cnt != 2'd0;
  assign job_out  = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= job_in;
    end
  end

endmodule

FILE: hw/rtl/cscs_front.sv
// Front section: takes scores, applies the tanh soft cap when one is set, stores them in the
// row buffer and tracks the causal maximum. Uses cscs_pkg, cscs_div, cscs_exp.
module cscs_front import cscs_pkg::*; #(
  parameter int MAX_SEQ = 64,
  localparam int AW  = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1,
  localparam int RAW = AW + 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  item_t                     item,
  output logic                      busy,
  input  logic [LEN_W-1:0]          seq_len,
  input  logic [CAP_W-1:0]          soft_cap,
  output logic                      wr_en,
  output logic [RAW-1:0]            wr_addr,
  output logic signed [SCORE_W-1:0] wr_data,
  output logic                      push,
  output job_t                      job,
  input  rel_t                      rel
);

  localparam int D1_NW = SCORE_W + 11;
  localparam int D1_QW = 14;
  localparam int MUL_W = CAP_W + ACC_W;
  localparam int D2_NW = MUL_W + 1;
  localparam int D2_DW = ACC_W + 1;
  localparam int D2_QW = SCORE_W;

  front_state_t state, state_next;

  logic [LEN_W-1:0]          count;
  logic [ROW_W-1:0]          held_row;
  logic signed [SCORE_W-1:0] running_max;
  logic                      bank;
  logic [1:0]                bank_busy;
  logic signed [SCORE_W-1:0] x;
  logic signed [SCORE_W-1:0] y;
  logic [ACC_W-1:0]          e_q;
  logic [MUL_W-1:0]          numer;

  logic [LEN_W-1:0]   len_eff;
  logic [LEN_W-1:0]   c;
  logic [SCORE_W-1:0] mag;
  logic               sat;
  logic               last;
  logic               upd;
  logic [ROW_W-1:0]   r_clamp;
  logic [LEN_W-1:0]   len_m1;
  logic               accept;

  logic               d1_start, d1_done;
  logic [D1_QW-1:0]   d1_q;
  logic               ex_start, ex_done;
  logic [EXPA_W-1:0]  ex_a;
  logic [ACC_W-1:0]   ex_res;
  logic               d2_start, d2_done;
  logic [D2_DW-1:0]   den2;
  logic [D2_QW-1:0]   d2_q;

  assign len_eff = (seq_len == '0) ? LEN_W'(1) :
                   (seq_len > LEN_W'(MAX_SEQ)) ? LEN_W'(MAX_SEQ) : seq_len;
  assign len_m1  = len_eff - 1'b1;
  assign c       = (count >= LEN_W'(MAX_SEQ)) ? LEN_W'(MAX_SEQ - 1) : count;
  assign mag     = x[SCORE_W-1] ? SCORE_W'(-x) : SCORE_W'(x);
  assign sat     = {2'b00, mag} >= {soft_cap, 3'b000};
  assign last    = (c + 1'b1) >= len_eff;
  assign upd     = (c <= {1'b0, held_row}) && (y > running_max);
  assign r_clamp = ({1'b0, held_row} > len_m1) ? ROW_W'(len_m1) : held_row;
  assign den2    = D2_DW'(ONE_Q30) + D2_DW'(e_q);

  assign busy   = (state != F_IDLE) || (count == '0 && bank_busy[bank]);
  assign accept = start && !busy;

  assign wr_en   = state == F_STORE;
  assign wr_addr = {bank, c[AW-1:0]};
  assign wr_data = y;
  assign push    = wr_en && last;
  assign job     = '{bank: bank, len: len_eff, row: r_clamp,
                     max: upd ? y : running_max};

  assign ex_a = (state == F_PREP) ? EXP_BIG : EXPA_W'(d1_q);

  cscs_div #(.NW(D1_NW), .DW(CAP_W), .QW(D1_QW)) u_div_ratio (
    .clk(clk), .rst(rst), .start(d1_start), .num({mag, 11'b0}), .den(soft_cap),
    .done(d1_done), .quo(d1_q)
  );

  cscs_exp u_exp (
    .clk(clk), .rst(rst), .start(ex_start), .a(ex_a), .done(ex_done), .res(ex_res)
  );

  cscs_div #(.NW(D2_NW), .DW(D2_DW), .QW(D2_QW)) u_div_tanh (
    .clk(clk), .rst(rst), .start(d2_start),
    .num(D2_NW'(numer) + D2_NW'(den2 >> 1)), .den(den2),
    .done(d2_done), .quo(d2_q)
  );

  always_comb begin
    state_next = state;
    d1_start   = 1'b0;
    ex_start   = 1'b0;
    d2_start   = 1'b0;
    case (state)
      F_IDLE: begin
        if (accept) state_next = F_PREP;
      end
      F_PREP: begin
        if (soft_cap == '0) begin
          state_next = F_STORE;
        end else if (sat) begin
          ex_start   = 1'b1;
          state_next = F_EXP;
        end else begin
          d1_start   = 1'b1;
          state_next = F_DIV1;
        end
      end
      F_DIV1: begin
        if (d1_done) begin
          ex_start   = 1'b1;
          state_next = F_EXP;
        end
      end
      F_EXP: begin
        if (ex_done) state_next = F_MUL;
      end
      F_MUL: state_next = F_DIVS;
      F_DIVS: begin
        d2_start   = 1'b1;
        state_next = F_DIV2;
      end
      F_DIV2: begin
        if (d2_done) state_next = F_STORE;
      end
      F_STORE: state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      count       <= '0;
      held_row    <= '0;
      running_max <= MOST_NEG;
      bank        <= 1'b0;
      bank_busy   <= 2'b00;
    end else begin
      state <= state_next;
      if (accept && count == '0) begin
        held_row    <= item.query_row;
        running_max <= MOST_NEG;
      end
      if (state == F_STORE) begin
        if (last) begin
          count       <= '0;
          running_max <= MOST_NEG;
          bank        <= ~bank;
        end else begin
          count <= c + 1'b1;
          if (upd) running_max <= y;
        end
      end
      for (int k = 0; k < 2; k++) begin
        if (push && bank == 1'(k)) begin
          bank_busy[k] <= 1'b1;
        end else if (rel.valid && rel.bank == 1'(k)) begin
          bank_busy[k] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) x <= item.score;
    if (state == F_PREP && soft_cap == '0) y <= x;
    if (state == F_EXP && ex_done) e_q <= ex_res;
    if (state == F_MUL) numer <= MUL_W'(soft_cap) * MUL_W'(ONE_Q30 - e_q);
    if (state == F_DIV2 && d2_done) begin
      y <= x[SCORE_W-1] ? SCORE_W'(-d2_q) : SCORE_W'(d2_q);
    end
  end

endmodule

FILE: hw/rtl/cscs_back.sv
// Back section: exp-sum pass and normalize/emit pass over one stored row.
// Uses cscs_pkg, cscs_exp, cscs_div and cscs_ram for the exponentials.
module cscs_back import cscs_pkg::*; #(
  parameter int MAX_SEQ = 64,
  localparam int AW  = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1,
  localparam int RAW = AW + 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_valid,
  input  job_t                      job_in,
  output logic                      pop,
  output logic [RAW-1:0]            rd_addr,
  input  logic signed [SCORE_W-1:0] rd_data,
  output result_t                   result,
  output logic                      result_valid,
  output rel_t                      rel
);

  localparam int PN_W = EV_W + 16 + 1;
  localparam int PQ_W = PROB_W + 1;

  back_state_t state, state_next;

  job_t             cur;
  logic [LEN_W-1:0] j;
  logic [SUM_W-1:0] exp_sum;

  logic              ex_start, ex_done;
  logic [EXPA_W-1:0] diff_a;
  logic [ACC_W-1:0]  ex_res;
  logic [ACC_W:0]    ev_round;
  logic [EV_W-1:0]   ev;
  logic              ev_we;
  logic [EV_W-1:0]   ev_rd;
  logic              dv_start, dv_done;
  logic [PQ_W-1:0]   dv_q;
  logic              zero_col;
  logic              col_last;
  logic              emit;
  logic [PROB_W-1:0] p_val;

  assign rd_addr  = {cur.bank, j[AW-1:0]};
  assign diff_a   = EXPA_W'({cur.max[SCORE_W-1], cur.max} - {rd_data[SCORE_W-1], rd_data});
  assign ev_round = {1'b0, ex_res} + (ACC_W+1)'(1 << 13);
  assign ev       = EV_W'(ev_round >> 14);
  assign zero_col = (j > {1'b0, cur.row}) || (exp_sum == '0);
  assign col_last = j == (cur.len - 1'b1);
  assign p_val    = zero_col ? '0 :
                    (dv_q > PQ_W'(PROB_ONE)) ? PROB_ONE : dv_q[PROB_W-1:0];

  cscs_exp u_exp (
    .clk(clk), .rst(rst), .start(ex_start), .a(diff_a), .done(ex_done), .res(ex_res)
  );

  cscs_ram #(.W(EV_W), .DEPTH(1 << AW)) u_ev_ram (
    .clk(clk), .we(ev_we), .waddr(j[AW-1:0]), .wdata(ev),
    .raddr(j[AW-1:0]), .rdata(ev_rd)
  );

  cscs_div #(.NW(PN_W), .DW(SUM_W), .QW(PQ_W)) u_div (
    .clk(clk), .rst(rst), .start(dv_start),
    .num(PN_W'({ev_rd, 16'h0000}) + PN_W'(exp_sum >> 1)), .den(exp_sum),
    .done(dv_done), .quo(dv_q)
  );

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    ex_start   = 1'b0;
    ev_we      = 1'b0;
    dv_start   = 1'b0;
    emit       = 1'b0;
    case (state)
      B_IDLE: begin
        if (job_valid) begin
          pop        = 1'b1;
          state_next = B_RD;
        end
      end
      B_RD: state_next = B_EXS;
      B_EXS: begin
        ex_start   = 1'b1;
        state_next = B_EXW;
      end
      B_EXW: begin
        if (ex_done) begin
          ev_we      = 1'b1;
          state_next = (j == {1'b0, cur.row}) ? B_P2 : B_RD;
        end
      end
      B_P2: begin
        if (zero_col) begin
          emit       = 1'b1;
          state_next = col_last ? B_IDLE : B_P2;
        end else begin
          state_next = B_P2W;
        end
      end
      B_P2W: begin
        dv_start   = 1'b1;
        state_next = B_P2D;
      end
      B_P2D: begin
        if (dv_done) begin
          emit       = 1'b1;
          state_next = col_last ? B_IDLE : B_P2;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  assign rel = '{valid: emit && col_last, bank: cur.bank};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
      exp_sum      <= '0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
      if (pop) exp_sum <= '0;
      if (ev_we) exp_sum <= exp_sum + SUM_W'(ev);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= job_in;
      j   <= '0;
    end
    if (ev_we) begin
      j <= (j == {1'b0, cur.row}) ? '0 : j + 1'b1;
    end
    if (emit) begin
      j      <= j + 1'b1;
      result <= '{probability: p_val, column: ROW_W'(j), row_end: col_last};
    end
  end

endmodule
